@@ design/dirty_tile_run_tracker_defines.svh @@
// ----------------------------------------------------------------------------
// dirty_tile_run_tracker_defines
// Assertion macros used by the checker file of the tile tracker.
// ----------------------------------------------------------------------------
`ifndef DIRTY_TILE_RUN_TRACKER_DEFINES_SVH
`define DIRTY_TILE_RUN_TRACKER_DEFINES_SVH

// clocked check, off while reset is high
`define DTR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check, active through reset as well
`define DTR_ASSERT_NR(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/dtr_pkg.sv @@
// ----------------------------------------------------------------------------
// dtr_pkg
// Types and constants of the dirty tile run tracker.
// ----------------------------------------------------------------------------
package dtr_pkg;

   localparam int BITMAP_BITS  = 128;
   localparam int WORD_BITS    = 64;
   localparam int BITMAP_WORDS = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W   = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam int WORD_SH      = $clog2(WORD_BITS);
   localparam int BIT_IDX_W    = $clog2(BITMAP_BITS);
   localparam int CNT_W        = BIT_IDX_W + 1;

   localparam int CHUNK_BITS   = 16;
   localparam int CHUNK_SH     = $clog2(CHUNK_BITS);
   localparam int CHUNK_IDX_W  = WORD_SH - CHUNK_SH;
   localparam int SCAN_W       = BIT_IDX_W - CHUNK_SH;

   localparam int TILE_BYTES   = 8;
   localparam int TILE_PIXELS  = 8;
   localparam int TILE_SHIFT   = $clog2(TILE_PIXELS);

   localparam int COORD_W      = 8;
   localparam int PIX_W        = 16;
   localparam int BASE_W       = 2 * COORD_W;
   localparam int RANGE_W      = BASE_W + 1;

   localparam int DIV_STEPS    = BIT_IDX_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = COORD_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_TILES  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT_TILES = 1'b1;

   typedef enum logic [1:0] {
      OP_MARK  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_TAKE  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef struct packed {
      op_type             opcode;
      logic [PIX_W-1:0]   rect_x;
      logic [PIX_W-1:0]   rect_y;
      logic [PIX_W-1:0]   rect_width;
      logic [PIX_W-1:0]   rect_height;
      logic [PIX_W-1:0]   max_data_bytes;
   } req_type;

   typedef struct packed {
      logic                 run_found;
      logic [BIT_IDX_W-1:0] run_col;
      logic [BIT_IDX_W-1:0] run_row;
      logic [CNT_W-1:0]     run_length;
      logic                 any_dirty;
   } rsp_type;

   typedef struct packed {
      logic                 done;
      logic [BIT_IDX_W-1:0] quot;
      logic [BIT_IDX_W-1:0] rem;
   } div_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MARK_SETUP,
      S_MARK_ROW,
      S_CLEAR,
      S_TAKE_SETUP,
      S_SCAN_RD,
      S_SCAN,
      S_DIV,
      S_TAKE_ROW,
      S_TAKE_END,
      S_CLR_SETUP,
      S_APPLY_RD,
      S_APPLY_WR,
      S_RESP
   } state_type;

endpackage

@@ design/dtr_ram.sv @@
// ----------------------------------------------------------------------------
// dtr_ram
// Bitmap word store, one write and one registered read port. Per-word valid
// bits make unwritten or cleared words read as zero.
// ----------------------------------------------------------------------------
module dtr_ram
   import dtr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic                  wr_en,
   input  logic [WORD_IDX_W-1:0] wr_addr,
   input  logic [WORD_BITS-1:0]  wr_data,
   input  logic                  rd_en,
   input  logic [WORD_IDX_W-1:0] rd_addr,
   output logic [WORD_BITS-1:0]  rd_data
);

   logic [WORD_BITS-1:0]    mem_ff [BITMAP_WORDS];
   logic [BITMAP_WORDS-1:0] valid_ff;
   logic [WORD_BITS-1:0]    rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/dtr_div.sv @@
// ----------------------------------------------------------------------------
// dtr_div
// Restoring divider, one quotient bit per cycle: tile index by grid width.
// ----------------------------------------------------------------------------
module dtr_div
   import dtr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [BIT_IDX_W-1:0] dividend,
   input  logic [COORD_W-1:0]   divisor,
   output div_status_type       status
);

   logic [COORD_W-1:0]   rem_ff, rem_in;
   logic [BIT_IDX_W-1:0] quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [COORD_W:0]     trial;
   logic [COORD_W:0]     diff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[BIT_IDX_W-1]};
      diff    = trial - {1'b0, divisor};
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[COORD_W-1:0];
            quo_in = {quo_ff[BIT_IDX_W-2:0], 1'b1};
         end else begin
            rem_in = trial[COORD_W-1:0];
            quo_in = {quo_ff[BIT_IDX_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign status.done = done_ff;
   assign status.quot = quo_ff;
   assign status.rem  = rem_ff[BIT_IDX_W-1:0];

endmodule

@@ design/dirty_tile_run_tracker.sv @@
// ----------------------------------------------------------------------------
// dirty_tile_run_tracker
// Dirty tile bitmap for partial display refresh: mark, clear and take-run.
// ----------------------------------------------------------------------------
// One request at a time: start is taken while busy is low, and its response
// shows on rsp_valid for one cycle as busy falls; it must be captured then,
// there is no way to hold it off. The 128-bit bitmap sits in a two-word RAM
// with a registered read; mark and take-run change it by a read and a write
// back per word, clear through the valid bits. Mark runs the row walker over
// each covered tile row that starts inside the bitmap, none for an empty
// rectangle or grid. Take makes up to two 16-bit-per-cycle scans of the
// bitmap, pausing for a RAM read per word, waits on the divider for row and
// column, then writes back the cleared run, unless no run is possible.
// Reset clears the bitmap at once through the valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module dirty_tile_run_tracker
   import dtr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [COORD_W-1:0]      width_ff, width_in, height_ff, height_in;
   logic [BITMAP_WORDS-1:0] nz_ff, nz_in;
   logic [BITMAP_BITS-1:0]  acc_ff, acc_in;
   logic [COORD_W-1:0]      sx_ff, sx_in, ex_ff, ex_in, ey_ff, ey_in, ty_ff, ty_in;
   logic [BASE_W-1:0]       base_ff, base_in;
   logic [WORD_IDX_W-1:0]   wi_ff, wi_in;
   logic                    apply_or_ff, apply_or_in;
   logic [SCAN_W-1:0]       scan_ff, scan_in;
   logic                    srch_set_ff, srch_set_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in, rowend_ff, rowend_in, end_ff, end_in;
   logic [CNT_W-1:0]        j_ff, j_in, len_ff, len_in;
   logic [BIT_IDX_W-1:0]    first_ff, first_in, col_ff, col_in, row_ff, row_in;
   logic                    found_ff, found_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    ram_clear, ram_wr_en, ram_rd_en;
   logic [WORD_IDX_W-1:0]   ram_wr_addr, ram_rd_addr;
   logic [WORD_BITS-1:0]    ram_wr_data, ram_rd_data;
   logic                    div_start;
   div_status_type          div_status;

   logic [CHUNK_BITS-1:0]   chunk;
   logic                    hit;
   logic [BIT_IDX_W-1:0]    hit_pos;
   logic                    scan_last, chunk_last, wi_last;
   logic [WORD_BITS-1:0]    acc_word;
   logic [PIX_W-1:0]        max_tiles;
   logic [PIX_W+1:0]        x_end, y_end;
   logic [COORD_W-1:0]      sx_c, sy_c, ex_c, ey_c;
   logic                    mark_empty;
   logic [RANGE_W-1:0]      row_lo, row_hi;
   logic                    row_stop;
   logic                    take_norun;
   logic [BASE_W-1:0]       wh_prod, rowend_prod;
   logic [CNT_W-1:0]        lim, step, stop;

   function automatic logic [COORD_W-1:0] clip(input logic [PIX_W+1:0] v,
                                               input logic [COORD_W-1:0] lim_v);
      return (v < (PIX_W+2)'(lim_v)) ? v[COORD_W-1:0] : lim_v;
   endfunction

   function automatic logic [BITMAP_BITS-1:0] range_mask(input logic [RANGE_W-1:0] lo,
                                                         input logic [RANGE_W-1:0] hi);
      logic [BITMAP_BITS-1:0] m;
      for (int i = 0; i < BITMAP_BITS; i++) begin
         m[i] = (RANGE_W'(i) >= lo) && (RANGE_W'(i) < hi);
      end
      return m;
   endfunction

   dtr_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .clear   (ram_clear),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dtr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (hit_pos),
      .divisor  (width_ff),
      .status   (div_status)
   );

   // chunk search and shared helpers
   always_comb begin
      logic [BIT_IDX_W-1:0] idx;
      logic                 pred;
      chunk   = ram_rd_data[{scan_ff[CHUNK_IDX_W-1:0], {CHUNK_SH{1'b0}}} +: CHUNK_BITS];
      hit     = 1'b0;
      hit_pos = '0;
      for (int k = CHUNK_BITS - 1; k >= 0; k--) begin
         idx  = {scan_ff, CHUNK_SH'(k)};
         pred = srch_set_ff ? (chunk[k] && ({1'b0, idx} < cnt_ff))
                            : (!chunk[k] && (idx >= first_ff));
         if (pred) begin
            hit     = 1'b1;
            hit_pos = idx;
         end
      end
      scan_last  = (scan_ff == {SCAN_W{1'b1}});
      chunk_last = (scan_ff[CHUNK_IDX_W-1:0] == {CHUNK_IDX_W{1'b1}});
      wi_last    = (wi_ff == WORD_IDX_W'(BITMAP_WORDS - 1));
      acc_word   = acc_ff[{wi_ff, {WORD_SH{1'b0}}} +: WORD_BITS];
      max_tiles  = req_ff.max_data_bytes / PIX_W'(TILE_BYTES);

      x_end = {2'b00, req_ff.rect_x} + {2'b00, req_ff.rect_width}
              + (PIX_W+2)'(TILE_PIXELS - 1);
      y_end = {2'b00, req_ff.rect_y} + {2'b00, req_ff.rect_height}
              + (PIX_W+2)'(TILE_PIXELS - 1);
      sx_c  = clip({2'b00, req_ff.rect_x} >> TILE_SHIFT, width_ff);
      sy_c  = clip({2'b00, req_ff.rect_y} >> TILE_SHIFT, height_ff);
      ex_c  = clip(x_end >> TILE_SHIFT, width_ff);
      ey_c  = clip(y_end >> TILE_SHIFT, height_ff);
      mark_empty = (req_ff.rect_width == '0) || (req_ff.rect_height == '0)
                   || (width_ff == '0) || (height_ff == '0)
                   || (sx_c >= ex_c) || (sy_c >= ey_c);

      row_lo   = {1'b0, base_ff} + RANGE_W'(sx_ff);
      row_hi   = {1'b0, base_ff} + RANGE_W'(ex_ff);
      row_stop = (ty_ff >= ey_ff) || (row_lo >= RANGE_W'(BITMAP_BITS));

      take_norun  = !(|nz_ff) || (max_tiles == '0) || (width_ff == '0);
      wh_prod     = BASE_W'(width_ff) * BASE_W'(height_ff);
      rowend_prod = (BASE_W'(row_ff) + BASE_W'(1)) * BASE_W'(width_ff);
      lim         = rowend_ff - CNT_W'(first_ff);
      step        = (PIX_W'(lim) < max_tiles) ? lim : max_tiles[CNT_W-1:0];
      stop        = (j_ff < end_ff) ? j_ff : end_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_data.opcode)
                  OP_MARK:  state_in = S_MARK_SETUP;
                  OP_CLEAR: state_in = S_CLEAR;
                  OP_TAKE:  state_in = S_TAKE_SETUP;
                  OP_NOP:   state_in = S_RESP;
                  default:  state_in = S_RESP;
               endcase
            end
         end
         S_MARK_SETUP: state_in = mark_empty ? S_RESP : S_MARK_ROW;
         S_MARK_ROW:   state_in = row_stop ? S_APPLY_RD : S_MARK_ROW;
         S_CLEAR:      state_in = S_RESP;
         S_TAKE_SETUP: state_in = take_norun ? S_RESP : S_SCAN_RD;
         S_SCAN_RD:    state_in = S_SCAN;
         S_SCAN: begin
            if (hit) begin
               state_in = srch_set_ff ? S_DIV : S_CLR_SETUP;
            end else if (scan_last) begin
               state_in = srch_set_ff ? S_RESP : S_CLR_SETUP;
            end else if (chunk_last) begin
               state_in = S_SCAN_RD;
            end
         end
         S_DIV:        state_in = div_status.done ? S_TAKE_ROW : S_DIV;
         S_TAKE_ROW:   state_in = S_TAKE_END;
         S_TAKE_END:   state_in = S_SCAN_RD;
         S_CLR_SETUP:  state_in = S_APPLY_RD;
         S_APPLY_RD:   state_in = S_APPLY_WR;
         S_APPLY_WR:   state_in = wi_last ? S_RESP : S_APPLY_RD;
         S_RESP:       state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // memory and divider controls
   always_comb begin
      ram_clear   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = wi_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wi_ff;
      ram_wr_data = apply_or_ff ? (ram_rd_data | acc_word) : (ram_rd_data & ~acc_word);
      div_start   = 1'b0;
      unique case (state_ff)
         S_CLEAR:    ram_clear = 1'b1;
         S_SCAN_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = scan_ff[SCAN_W-1 -: WORD_IDX_W];
         end
         S_SCAN:     div_start = hit && srch_set_ff;
         S_APPLY_RD: ram_rd_en = 1'b1;
         S_APPLY_WR: ram_wr_en = 1'b1;
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      req_in       = req_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      nz_in        = nz_ff;
      acc_in       = acc_ff;
      sx_in        = sx_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      ty_in        = ty_ff;
      base_in      = base_ff;
      wi_in        = wi_ff;
      apply_or_in  = apply_or_ff;
      scan_in      = scan_ff;
      srch_set_in  = srch_set_ff;
      cnt_in       = cnt_ff;
      rowend_in    = rowend_ff;
      end_in       = end_ff;
      j_in         = j_ff;
      len_in       = len_ff;
      first_in     = first_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      found_in     = found_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_WIDTH_TILES:  width_in  = csr_wdata;
            CSR_HEIGHT_TILES: height_in = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               found_in = 1'b0;
               col_in   = '0;
               row_in   = '0;
               len_in   = '0;
            end
         end
         S_MARK_SETUP: begin
            sx_in       = sx_c;
            ex_in       = ex_c;
            ey_in       = ey_c;
            ty_in       = sy_c;
            base_in     = BASE_W'(sy_c) * BASE_W'(width_ff);
            acc_in      = '0;
            wi_in       = '0;
            apply_or_in = 1'b1;
         end
         S_MARK_ROW: begin
            if (!row_stop) begin
               acc_in  = acc_ff | range_mask(row_lo, row_hi);
               ty_in   = ty_ff + COORD_W'(1);
               base_in = base_ff + BASE_W'(width_ff);
            end
         end
         S_CLEAR: nz_in = '0;
         S_TAKE_SETUP: begin
            cnt_in      = (wh_prod > BASE_W'(BITMAP_BITS)) ? CNT_W'(BITMAP_BITS)
                                                          : wh_prod[CNT_W-1:0];
            scan_in     = '0;
            srch_set_in = 1'b1;
         end
         S_SCAN: begin
            if (hit) begin
               if (srch_set_ff) begin
                  first_in = hit_pos;
               end else begin
                  j_in = CNT_W'(hit_pos);
               end
            end else if (!scan_last) begin
               scan_in = scan_ff + SCAN_W'(1);
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               row_in = div_status.quot;
               col_in = div_status.rem;
            end
         end
         S_TAKE_ROW: begin
            rowend_in = (rowend_prod < BASE_W'(cnt_ff)) ? rowend_prod[CNT_W-1:0] : cnt_ff;
         end
         S_TAKE_END: begin
            end_in      = CNT_W'(first_ff) + step;
            j_in        = CNT_W'(BITMAP_BITS);
            scan_in     = '0;
            srch_set_in = 1'b0;
         end
         S_CLR_SETUP: begin
            len_in      = stop - CNT_W'(first_ff);
            found_in    = 1'b1;
            acc_in      = range_mask(RANGE_W'(first_ff), RANGE_W'(stop));
            wi_in       = '0;
            apply_or_in = 1'b0;
         end
         S_APPLY_WR: begin
            nz_in[wi_ff] = |ram_wr_data;
            if (!wi_last) begin
               wi_in = wi_ff + WORD_IDX_W'(1);
            end
         end
         S_RESP: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.run_found  = found_ff;
            rsp_data_in.run_col    = col_ff;
            rsp_data_in.run_row    = row_ff;
            rsp_data_in.run_length = len_ff;
            rsp_data_in.any_dirty  = |nz_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= '0;
         height_ff    <= '0;
         nz_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         nz_ff        <= nz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      acc_ff      <= acc_in;
      sx_ff       <= sx_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      ty_ff       <= ty_in;
      base_ff     <= base_in;
      wi_ff       <= wi_in;
      apply_or_ff <= apply_or_in;
      scan_ff     <= scan_in;
      srch_set_ff <= srch_set_in;
      cnt_ff      <= cnt_in;
      rowend_ff   <= rowend_in;
      end_ff      <= end_in;
      j_ff        <= j_in;
      len_ff      <= len_in;
      first_ff    <= first_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ design/dtr_checker.sv @@
// ----------------------------------------------------------------------------
// dtr_checker
// Port-level checks of the tile tracker request/response sequencing.
// ----------------------------------------------------------------------------
`include "dirty_tile_run_tracker_defines.svh"

module dtr_checker
   import dtr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   `DTR_ASSERT(a_accept_busy, (start && !busy) |=> busy, "request accepted but busy stays low")
   `DTR_ASSERT(a_done_strobe, (!$past(reset) && $fell(busy)) |-> rsp_valid, "busy fell without response")
   `DTR_ASSERT_NR(a_single_strobe, rsp_valid |=> !rsp_valid, "response strobe longer than one cycle")
   `DTR_ASSERT(a_norun_zero, (rsp_valid && !rsp_data.run_found) |-> (rsp_data.run_length == '0 && rsp_data.run_col == '0 && rsp_data.run_row == '0), "run fields set without a run")

endmodule

bind dirty_tile_run_tracker dtr_checker u_dtr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
